FILE: rtl/tdbe_pkg.sv
// ----------------------------------------------------------------------------
// tdbe_pkg
// Shared types and constants of the timestamp delta byte encoder.
// ----------------------------------------------------------------------------
package tdbe_pkg;

	// Action codes
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// Byte count limits of one job and the job queue depth
	localparam int MAX_BYTES   = 8;
	localparam int COUNT_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	// Delta limits as bit positions: long tokens hold up to 28 bits
	localparam int DELTA_BITS = 28;
	localparam int CODE3_BIT  = 20;
	localparam int CODE2_BIT  = 12;

	// Long token length codes
	localparam logic [1:0] LEN_CODE1 = 2'd1;
	localparam logic [1:0] LEN_CODE2 = 2'd2;
	localparam logic [1:0] LEN_CODE3 = 2'd3;

	// Token bytes and marks
	localparam logic [7:0] ZERO_TOKEN  = 8'h00;
	localparam logic [7:0] ONE_TOKEN   = 8'h20;
	localparam logic [7:0] SECOND_ZERO = 8'h08;
	localparam logic [7:0] SECOND_ONE  = 8'h04;
	localparam logic [7:0] THIRD_ZERO  = 8'h02;
	localparam logic [7:0] THIRD_ONE   = 8'h01;
	localparam logic [7:0] MARK_MASK   = 8'hC0;
	localparam logic [7:0] MARK_ZERO   = 8'h40;
	localparam logic [7:0] MARK_ONE    = 8'h80;
	localparam logic [3:0] NIBBLE      = 4'hF;
	localparam logic [2:0] PEND_EMPTY  = 3'd0;
	localparam logic [2:0] PEND_SHORT  = 3'd1;

	// Input item
	typedef struct packed {
		logic        action;
		logic [63:0] timestamp;
	} in_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       error;
		logic       last;
	} out_t;

	// Byte job passed from the front to the back, bytes sent from index 0
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [COUNT_W-1:0]        count;
		logic                      err;
	} job_t;

endpackage

FILE: rtl/tdbe_stream_if.sv
// ----------------------------------------------------------------------------
// tdbe_stream_if
// Valid/ready stream channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface tdbe_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tdbe_front.sv
// ----------------------------------------------------------------------------
// tdbe_front
// Accepts timestamps, tracks the delta state and the pending token, and
// turns each item into one job of up to eight bytes for the back end.
// ----------------------------------------------------------------------------
module tdbe_front (
	input  logic           clk,
	input  logic           arst_n,
	tdbe_stream_if.sink    ts_chan,
	tdbe_stream_if.source  job_chan
);

	logic [63:0]      prev_ts_q;
	logic             first_seen_q;
	logic [2:0]       pend_len_q;
	logic [3:0][7:0]  pend_q;

	logic [63:0]      prev_ts_d;
	logic             first_seen_d;
	logic [2:0]       pend_len_d;
	logic [3:0][7:0]  pend_d;

	logic [64:0]      diff;
	logic [63:0]      delta;
	logic             bad;
	logic             is_small;
	logic [1:0]       li;
	logic [7:0]       mark;
	logic [1:0]       code;
	logic             accept;
	tdbe_pkg::in_t    item;
	tdbe_pkg::job_t   job;

	assign item   = ts_chan.data;
	assign accept = ts_chan.valid && ts_chan.ready;

	// Delta with borrow; out of range when negative or 2^28 or more
	assign diff     = {1'b0, item.timestamp} - {1'b0, prev_ts_q};
	assign delta    = diff[63:0];
	assign bad      = diff[64] || (|delta[63:tdbe_pkg::DELTA_BITS]);
	assign is_small = ~|delta[63:1];
	assign li       = 2'(pend_len_q - 3'd1);
	assign mark     = pend_q[li] & tdbe_pkg::MARK_MASK;

	// Length code of a long token
	always_comb begin
		if (|delta[tdbe_pkg::DELTA_BITS-1:tdbe_pkg::CODE3_BIT]) begin
			code = tdbe_pkg::LEN_CODE3;
		end else if (|delta[tdbe_pkg::CODE3_BIT-1:tdbe_pkg::CODE2_BIT]) begin
			code = tdbe_pkg::LEN_CODE2;
		end else begin
			code = tdbe_pkg::LEN_CODE1;
		end
	end

	// Classify the item, build its job and the next state
	always_comb begin
		prev_ts_d    = prev_ts_q;
		first_seen_d = first_seen_q;
		pend_len_d   = pend_len_q;
		pend_d       = pend_q;
		job.bytes    = '0;
		job.count    = '0;
		job.err      = 1'b0;

		if (item.action == tdbe_pkg::ACT_FLUSH) begin
			// Send what is pending
			job.bytes[3:0] = pend_q;
			job.count      = tdbe_pkg::COUNT_W'(pend_len_q);
			pend_len_d     = tdbe_pkg::PEND_EMPTY;
		end else if (!first_seen_q) begin
			// First timestamp goes out whole, most significant byte first
			for (int k = 0; k < tdbe_pkg::MAX_BYTES; k++) begin
				job.bytes[k] = item.timestamp[8*(tdbe_pkg::MAX_BYTES-1-k) +: 8];
			end
			job.count    = tdbe_pkg::COUNT_W'(tdbe_pkg::MAX_BYTES);
			prev_ts_d    = item.timestamp;
			first_seen_d = 1'b1;
		end else if (bad) begin
			// Error marker, state held
			job.bytes[0] = 8'h00;
			job.count    = tdbe_pkg::COUNT_W'(1);
			job.err      = 1'b1;
		end else begin
			prev_ts_d = item.timestamp;
			if (is_small) begin
				if (pend_len_q == tdbe_pkg::PEND_EMPTY) begin
					// Open a one-byte token
					pend_d[0]  = delta[0] ? tdbe_pkg::ONE_TOKEN : tdbe_pkg::ZERO_TOKEN;
					pend_len_d = tdbe_pkg::PEND_SHORT;
				end else if (pend_len_q == tdbe_pkg::PEND_SHORT) begin
					if ((pend_q[0][3:0] & tdbe_pkg::NIBBLE) == 4'h0) begin
						pend_d[0] = pend_q[0] |
							(delta[0] ? tdbe_pkg::SECOND_ONE : tdbe_pkg::SECOND_ZERO);
					end else begin
						// Third delta closes the one-byte token
						job.bytes[0] = pend_q[0] |
							(delta[0] ? tdbe_pkg::THIRD_ONE : tdbe_pkg::THIRD_ZERO);
						job.count    = tdbe_pkg::COUNT_W'(1);
						pend_len_d   = tdbe_pkg::PEND_EMPTY;
					end
				end else begin
					// Mark the last byte of a long token
					job.bytes[3:0] = pend_q;
					if (!delta[0]) begin
						if (mark == 8'h00) begin
							pend_d[li] = pend_q[li] | tdbe_pkg::MARK_ZERO;
						end else begin
							job.bytes[li] = pend_q[li] | tdbe_pkg::MARK_MASK;
							job.count     = tdbe_pkg::COUNT_W'(pend_len_q);
							pend_len_d    = tdbe_pkg::PEND_EMPTY;
						end
					end else begin
						if (mark == 8'h00) begin
							job.bytes[li] = pend_q[li] | tdbe_pkg::MARK_ONE;
							job.count     = tdbe_pkg::COUNT_W'(pend_len_q);
						end else begin
							// Send the token unchanged, then a lone one-token
							job.bytes[pend_len_q] = tdbe_pkg::ONE_TOKEN;
							job.count = tdbe_pkg::COUNT_W'(pend_len_q) +
								tdbe_pkg::COUNT_W'(1);
						end
						pend_len_d = tdbe_pkg::PEND_EMPTY;
					end
				end
			end else begin
				// Send what is pending and open a long token
				job.bytes[3:0] = pend_q;
				job.count      = tdbe_pkg::COUNT_W'(pend_len_q);
				pend_d[0]      = {code, delta[5:0]};
				pend_d[1]      = delta[13:6];
				pend_d[2]      = delta[21:14];
				pend_d[3]      = {2'b00, delta[27:22]};
				pend_len_d     = {1'b0, code} + 3'd1;
			end
		end
	end

	// Push only items that produce bytes; accept and push share one handshake
	assign job_chan.data  = job;
	assign job_chan.valid = ts_chan.valid && (job.count != '0);
	assign ts_chan.ready  = job_chan.ready;

	// Update control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ts_q    <= '0;
			first_seen_q <= 1'b0;
			pend_len_q   <= tdbe_pkg::PEND_EMPTY;
		end else if (accept) begin
			prev_ts_q    <= prev_ts_d;
			first_seen_q <= first_seen_d;
			pend_len_q   <= pend_len_d;
		end
	end

	// Hold the pending token bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= pend_d;
		end
	end

endmodule

FILE: rtl/tdbe_queue.sv
// ----------------------------------------------------------------------------
// tdbe_queue
// Small FIFO of byte jobs between the front and the back end.
// ----------------------------------------------------------------------------
module tdbe_queue #(
	parameter int DEPTH = tdbe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	tdbe_stream_if.sink    push,
	tdbe_stream_if.source  pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tdbe_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign push.ready = (fill_q != CNT_W'(DEPTH));
	assign pop.valid  = (fill_q != '0);
	assign pop.data   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

endmodule

FILE: rtl/tdbe_back.sv
// ----------------------------------------------------------------------------
// tdbe_back
// Serializes byte jobs into result items, one byte per cycle while the
// output is ready, through an output register.
// ----------------------------------------------------------------------------
module tdbe_back (
	input  logic           clk,
	input  logic           arst_n,
	tdbe_stream_if.sink    job_chan,
	tdbe_stream_if.source  byte_chan
);

	logic [2:0]      idx_q;
	logic            out_valid_q;
	tdbe_pkg::out_t  out_q;
	tdbe_pkg::job_t  job;
	logic            load;
	logic            is_last;

	assign job     = job_chan.data;
	assign load    = job_chan.valid && (!out_valid_q || byte_chan.ready);
	assign is_last = ((tdbe_pkg::COUNT_W'(idx_q) + tdbe_pkg::COUNT_W'(1)) == job.count);

	// Release the job with its final byte
	assign job_chan.ready  = load && is_last;
	assign byte_chan.valid = out_valid_q;
	assign byte_chan.data  = out_q;

	// Advance byte index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= is_last ? '0 : idx_q + 3'd1;
			out_valid_q <= 1'b1;
		end else if (byte_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= job.bytes[idx_q];
			out_q.error    <= job.err;
			out_q.last     <= is_last;
		end
	end

endmodule

FILE: rtl/timestamp_delta_byte_encoder_core.sv
// ----------------------------------------------------------------------------
// timestamp_delta_byte_encoder_core
// Compresses microsecond timestamps into a byte stream of delta tokens.
// ----------------------------------------------------------------------------
// A new item is accepted every cycle while the job queue has room; the front
// end classifies it in that same cycle and queues the bytes it releases (zero
// to eight). The back end sends one byte per cycle through an output
// register while the output port is ready. The first timestamp releases
// eight bytes, typical items zero to four, and an item that releases
// nothing queues no job. Sustained rate is set by the byte-wide output
// port. Error results (negative delta or one of 2^28 or more) are a single
// zero byte with error and last set.
// ----------------------------------------------------------------------------
module timestamp_delta_byte_encoder_core #(
	parameter int QUEUE_DEPTH = tdbe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	tdbe_stream_if.sink    ts_chan,
	tdbe_stream_if.source  byte_chan
);

	tdbe_stream_if #(.T(tdbe_pkg::job_t)) job_push ();
	tdbe_stream_if #(.T(tdbe_pkg::job_t)) job_pop ();

	// Classify items and track the pending token
	tdbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ts_chan  (ts_chan),
		.job_chan (job_push)
	);

	// Decouple front and back
	tdbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.pop    (job_pop)
	);

	// Serialize bytes
	tdbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_chan  (job_pop),
		.byte_chan (byte_chan)
	);

	// An error result stands alone as a zero byte
	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		byte_chan.valid && byte_chan.data.error |->
			byte_chan.data.last && (byte_chan.data.out_byte == 8'h00))
		else $error("error result not a lone zero byte");

	// Every queued job carries one to eight bytes
	a_job_count: assert property (@(posedge clk) disable iff (!arst_n)
		job_push.valid |-> (job_push.data.count != '0) &&
			(job_push.data.count <= tdbe_pkg::COUNT_W'(tdbe_pkg::MAX_BYTES)))
		else $error("job byte count out of range");

	// An error job holds exactly one byte
	a_error_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_push.valid && job_push.data.err |->
			(job_push.data.count == tdbe_pkg::COUNT_W'(1)))
		else $error("error job longer than one byte");

endmodule
